// ===== rtl/core/gbfv_pkg.sv =====
// shared types and constants for the binary frame validator
`timescale 1ns / 1ps
`default_nettype none

package gbfv_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND = 8'h62;
   localparam logic [16:0] OVERHEAD    = 17'd8;
   localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [16:0] SUM_START   = 17'd6;
   localparam logic [16:0] SUM_SECOND  = 17'd7;
   localparam logic [16:0] POS_LEN_LO  = 17'd4;
   localparam logic [16:0] POS_LEN_HI  = 17'd5;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;

   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_NOT_FRAME = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [16:0] frame_length;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/gbfv_frame_check.sv =====
// per-buffer frame state, fletcher-8 sums and verdict logic
`timescale 1ns / 1ps
`default_nettype none

module gbfv_frame_check
   import gbfv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        beat_valid,
   input  wire req_type     beat,
   input  wire logic [15:0] max_payload,
   output rsp_type          verdict
);

   logic [16:0] count_ff, count_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  first_sum_ff, first_sum_in;
   logic        first_bad_ff, first_bad_in;
   logic        second_bad_ff, second_bad_in;
   logic        ck_bad_ff, ck_bad_in;

   logic [16:0] len_sum_end;
   logic [16:0] len_ck_b;
   logic [16:0] len_total;
   logic [7:0]  b;

   always_comb begin
      b            = beat.data_byte;
      len_sum_end  = {1'b0, len_ff} + SUM_START;
      len_ck_b     = {1'b0, len_ff} + SUM_SECOND;
      count_in      = count_ff;
      len_in        = len_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      first_sum_in  = first_sum_ff;
      first_bad_in  = first_bad_ff;
      second_bad_in = second_bad_ff;
      ck_bad_in     = ck_bad_ff;

      if (count_ff == 17'd0) begin
         first_bad_in = (b != SYNC_FIRST);
      end else if (count_ff == 17'd1) begin
         second_bad_in = (b != SYNC_SECOND);
      end else if (count_ff < len_sum_end) begin
         if (count_ff == POS_LEN_LO) begin
            len_in = {8'h00, b};
         end else if (count_ff == POS_LEN_HI) begin
            len_in = {b, len_ff[7:0]};
         end
         sum_a_in = sum_a_ff + b;
         sum_b_in = sum_b_ff + sum_a_in;
      end else if (count_ff == len_sum_end) begin
         first_sum_in = b;
      end else if (count_ff == len_ck_b) begin
         ck_bad_in = (first_sum_ff != sum_a_ff) || (b != sum_b_ff);
      end

      if (count_ff != COUNT_MAX) begin
         count_in = count_ff + 17'd1;
      end
   end

   // verdict in precedence order
   always_comb begin
      len_total            = {1'b0, len_in} + OVERHEAD;
      verdict.frame_length = 17'd0;
      if (first_bad_in) begin
         verdict.status = STATUS_NOT_FRAME;
      end else if (count_in < OVERHEAD) begin
         verdict.status = STATUS_TRUNCATED;
      end else if (second_bad_in) begin
         verdict.status = STATUS_NOT_FRAME;
      end else if (len_in > max_payload) begin
         verdict.status = STATUS_NOT_FRAME;
      end else if (count_in < len_total) begin
         verdict.status = STATUS_TRUNCATED;
      end else if (ck_bad_in) begin
         verdict.status = STATUS_NOT_FRAME;
      end else begin
         verdict.status       = STATUS_VALID;
         verdict.frame_length = len_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_valid && beat.end_of_buffer)) begin
         count_ff      <= 17'd0;
         len_ff        <= 16'd0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         first_sum_ff  <= 8'd0;
         first_bad_ff  <= 1'b0;
         second_bad_ff <= 1'b0;
         ck_bad_ff     <= 1'b0;
      end else if (beat_valid) begin
         count_ff      <= count_in;
         len_ff        <= len_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         first_sum_ff  <= first_sum_in;
         first_bad_ff  <= first_bad_in;
         second_bad_ff <= second_bad_in;
         ck_bad_ff     <= ck_bad_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gnss_binary_frame_validator.sv =====
// top level of the binary frame validator: beat registers, config register, checker
// Takes one buffer byte per beat and gives a single verdict beat on the byte that
// carries end_of_buffer: valid frame with its total length, not a frame, or
// truncated. Throughput is one byte per clock cycle unless a last byte is held back
// waiting for the result register; a byte sits in the input register, passes the sum
// and compare logic and, if it is the last byte, lands its verdict in the result register.
// Bytes keep flowing while a verdict waits on rsp_stall; only a last byte waits
// until the result register is free. csr_data sets the largest accepted payload
// length (512 after reset) and is always ready; write it while no buffer is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_validator
   import gbfv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic        stage_valid_ff, stage_valid_in;
   req_type     stage_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic [15:0] max_payload_ff;
   logic        out_free;
   logic        stage_go;
   logic        req_take;
   rsp_type     verdict;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stage_go  = stage_valid_ff && (!stage_data_ff.end_of_buffer || out_free);
   assign req_stall = stage_valid_ff && !stage_go;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_go && stage_data_ff.end_of_buffer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   gbfv_frame_check u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (stage_go),
      .beat        (stage_data_ff),
      .max_payload (max_payload_ff),
      .verdict     (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_data_ff <= req_data;
      end
      if (stage_go && stage_data_ff.end_of_buffer) begin
         rsp_data_ff <= verdict;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for gnss_binary_frame_validator: byte stream in, frame verdicts checked
`timescale 1ns / 1ps

module tb_top;
   import gbfv_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BYTES = 330;

   typedef struct packed {
      logic [7:0]  b;
      logic        last;
      logic        typed;
      logic [1:0]  status;
      logic [16:0] flen;
   } dir_row_type;

   // first sync byte alone, bad first byte alone, short buffer with bad second
   // byte, minimal valid frame with a trailing byte, declared length above the limit
   dir_row_type directed_rows [21] = '{
      '{8'hB5, 1'b1, 1'b1, STATUS_TRUNCATED, 17'd0},
      '{8'hFF, 1'b1, 1'b1, STATUS_NOT_FRAME, 17'd0},
      '{8'hB5, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h00, 1'b1, 1'b1, STATUS_TRUNCATED, 17'd0},
      '{8'hB5, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h62, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h01, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h02, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h00, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h00, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h03, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h0A, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'hFF, 1'b1, 1'b0, STATUS_VALID, 17'd0},
      '{8'hB5, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h62, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h01, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h02, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'hFF, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'hFF, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h00, 1'b0, 1'b0, STATUS_VALID, 17'd0},
      '{8'h00, 1'b1, 1'b1, STATUS_NOT_FRAME, 17'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // predictor state for the buffer being scanned
   logic [16:0] scan_count = '0;
   logic [15:0] scan_len = '0;
   logic [7:0]  scan_a = '0;
   logic [7:0]  scan_b = '0;
   logic [7:0]  scan_ck_a = '0;
   logic        scan_first_bad = 1'b0;
   logic        scan_second_bad = 1'b0;
   logic        scan_ck_bad = 1'b0;
   logic [15:0] scan_max = MAX_PAYLOAD_RESET;

   rsp_type     verdicts_due [$];
   logic [7:0]  buf_q [$];
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          idle_pct = 20;
   int          quiet_cycles = 0;
   bit          hold_go = 1'b0;

   gnss_binary_frame_validator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic predict_verdict(input logic [7:0] b, input logic last,
                                  output logic got, output rsp_type verdict);
      logic [16:0] pos;
      logic [16:0] body_end;
      logic [16:0] need;
      pos = scan_count;
      body_end = {1'b0, scan_len} + SUM_START;
      got = 1'b0;
      verdict = '0;
      if (pos == 17'd0) begin
         scan_first_bad = (b != SYNC_FIRST);
      end else if (pos == 17'd1) begin
         scan_second_bad = (b != SYNC_SECOND);
      end else if (pos < body_end) begin
         if (pos == POS_LEN_LO) begin
            scan_len = {8'h00, b};
         end else if (pos == POS_LEN_HI) begin
            scan_len = {b, scan_len[7:0]};
         end
         scan_a = scan_a + b;
         scan_b = scan_b + scan_a;
      end else if (pos == body_end) begin
         scan_ck_a = b;
      end else if (pos == body_end + 17'd1) begin
         scan_ck_bad = (scan_ck_a != scan_a) || (b != scan_b);
      end
      if (scan_count != COUNT_MAX) begin
         scan_count = scan_count + 17'd1;
      end
      if (last) begin
         need = {1'b0, scan_len} + OVERHEAD;
         got = 1'b1;
         if (scan_first_bad) begin
            verdict.status = STATUS_NOT_FRAME;
         end else if (scan_count < OVERHEAD) begin
            verdict.status = STATUS_TRUNCATED;
         end else if (scan_second_bad) begin
            verdict.status = STATUS_NOT_FRAME;
         end else if (scan_len > scan_max) begin
            verdict.status = STATUS_NOT_FRAME;
         end else if (scan_count < need) begin
            verdict.status = STATUS_TRUNCATED;
         end else if (scan_ck_bad) begin
            verdict.status = STATUS_NOT_FRAME;
         end else begin
            verdict.status = STATUS_VALID;
            verdict.frame_length = need;
         end
         scan_count = '0;
         scan_len = '0;
         scan_a = '0;
         scan_b = '0;
         scan_ck_a = '0;
         scan_first_bad = 1'b0;
         scan_second_bad = 1'b0;
         scan_ck_bad = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic typed, input rsp_type typed_rsp);
      logic    got;
      rsp_type pred;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, end_of_buffer: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_verdict(b, last, got, pred);
      if (got) begin
         verdicts_due.push_back(typed ? typed_rsp : pred);
      end
      bytes_sent++;
   endtask

   task automatic send_buf;
      for (int i = 0; i < buf_q.size(); i++) begin
         send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
      end
   endtask

   task automatic write_max(input logic [15:0] v);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scan_max = v;
   endtask

   task automatic make_frame(input logic [15:0] dlen, input int body_len);
      logic [7:0] ca;
      logic [7:0] cb;
      logic [7:0] v;
      buf_q.delete();
      buf_q.push_back(SYNC_FIRST);
      buf_q.push_back(SYNC_SECOND);
      ca = '0;
      cb = '0;
      for (int i = 0; i < 4 + body_len; i++) begin
         if (i == 2) begin
            v = dlen[7:0];
         end else if (i == 3) begin
            v = dlen[15:8];
         end else begin
            v = 8'($urandom);
         end
         buf_q.push_back(v);
         ca = ca + v;
         cb = cb + ca;
      end
      buf_q.push_back(ca);
      buf_q.push_back(cb);
   endtask

   task automatic random_buffer;
      logic [15:0] dlen;
      int          pick;
      int          body_len;
      int          idx;
      int          cut;
      if ($urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, 9);
         if (pick < 7 || scan_max > 16'd600) begin
            dlen = 16'($urandom_range(0, 12));
         end else if (pick == 7) begin
            dlen = 16'(int'(scan_max) + $urandom_range(0, 2) - 1);
         end else begin
            dlen = 16'($urandom);
         end
         body_len = (dlen <= 16'd600) ? int'(dlen) : $urandom_range(0, 8);
         make_frame(dlen, body_len);
         case ($urandom_range(0, 9))
            5: begin
               idx = $urandom_range(0, buf_q.size() - 1);
               buf_q[idx] = buf_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            6: begin
               cut = $urandom_range(1, buf_q.size() - 1);
               while (buf_q.size() > cut) void'(buf_q.pop_back());
            end
            7: begin
               repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
            end
            8: begin
               idx = $urandom_range(0, 1);
               buf_q[idx] = buf_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            9: begin
               buf_q[buf_q.size() - 1] = buf_q[buf_q.size() - 1] ^ 8'h01;
            end
            default: begin
            end
         endcase
      end else begin
         buf_q.delete();
         if ($urandom_range(0, 1) == 1) begin
            buf_q.push_back(SYNC_FIRST);
            if ($urandom_range(0, 1) == 1) buf_q.push_back(SYNC_SECOND);
         end
         repeat ($urandom_range(1, 12)) buf_q.push_back(8'($urandom));
      end
      send_buf();
   endtask

   // receiver side: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $error("unexpected verdict beat: status %0d frame_length %0d",
                   rsp_data.status, rsp_data.frame_length);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, rsp_data.frame_length);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_type     row_rsp;
      logic [15:0] max_plan [6];
      int          phase_start;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row_rsp.status = directed_rows[i].status;
         row_rsp.frame_length = directed_rows[i].flen;
         send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                   row_rsp);
      end

      // largest declared length with the limit wide open, buffer cut short
      write_max(16'hFFFF);
      make_frame(16'hFFFF, 4);
      send_buf();

      max_plan = '{16'd0, 16'd12, 16'hFFFF, 16'($urandom_range(0, 65535)), 16'd1,
                   MAX_PAYLOAD_RESET};
      for (int p = 0; p < 6; p++) begin
         write_max(max_plan[p]);
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 35;
         endcase
         if (p == 5) idle_pct = 0;
         if (p == 1) hold_go = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) random_buffer();
      end

      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/gbfv_pkg.sv
rtl/core/gbfv_frame_check.sv
rtl/core/gnss_binary_frame_validator.sv
tb/sv/tb_top.sv
